### rtl/sgt_pkg.sv
// ----------------------------------------------------------------------------
// sgt_pkg: shared types and constants for the segment tree range max block
// Widths of the node store, leaf counts, item kinds and the control states.
// ----------------------------------------------------------------------------
package sgt_pkg;

  localparam int TREE_LEAVES = 1024;
  localparam int STORE_DEPTH = 2 * TREE_LEAVES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PTR_W       = ADDR_W + 1;
  localparam int LEAF_W      = ADDR_W;
  localparam int POS_W       = 10;
  localparam int DATA_W      = 64;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [LEAF_W-1:0] leaf_cnt_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam word_t     MOST_NEG   = {1'b1, {(DATA_W-1){1'b0}}};
  localparam leaf_cnt_t LEAVES_MAX = LEAF_W'(TREE_LEAVES);
  localparam addr_t     ROOT_NODE  = ADDR_W'(1);

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_QUERY
  } state_t;

  function automatic word_t smax(input word_t a, input word_t b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

endpackage

### rtl/sgt_store.sv
// ----------------------------------------------------------------------------
// sgt_store: node store of the segment tree
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sgt_store import sgt_pkg::*; (
  input  logic  clk,
  input  logic  wr_en,
  input  addr_t wr_addr,
  input  word_t wr_data,
  input  addr_t rd_addr,
  output word_t rd_data
);

  word_t mem [STORE_DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/segment_tree_range_max.sv
// ----------------------------------------------------------------------------
// segment_tree_range_max: bottom-up segment tree, point update / range max
// Update: leaf write, then one parent write per tree level up to the root, no result.
// Query: up to two node reads and a shift per level, bounded by the single
//   store read port.
// One item at a time; a result waits in the output register while the next
//   item is taken. After reset a clearing pass writes every store entry
//   before the first item is accepted.
// ----------------------------------------------------------------------------
module segment_tree_range_max import sgt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // position[9:0], value[73:10], range_lo[84:74],
                                  // range_hi[95:85]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // max_value
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data // leaves_in_use
);

  state_t    state_r, state_nxt;
  addr_t     clr_cnt_r, clr_cnt_nxt;
  leaf_cnt_t leaves_r;
  addr_t     node_r, node_nxt;
  word_t     cur_r, cur_nxt;
  ptr_t      lo_r, lo_nxt;
  ptr_t      hi_r, hi_nxt;
  word_t     res_r, res_nxt;
  logic      rd_pend_r, rd_pend_nxt;
  logic      out_valid_r, out_valid_nxt;
  word_t     out_data_r, out_data_nxt;

  logic      mem_we;
  addr_t     mem_waddr;
  word_t     mem_wdata;
  addr_t     mem_raddr;
  word_t     mem_rdata;

  leaf_cnt_t n_eff;
  pos_t      in_pos;
  word_t     in_val;
  leaf_cnt_t in_lo, in_hi, lo_c, hi_c;
  addr_t     leaf_addr, parent;
  word_t     up_max;
  ptr_t      hi_dec;

  sgt_store u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    if (leaves_r == '0) begin
      n_eff = LEAF_W'(1);
    end else if (leaves_r > LEAVES_MAX) begin
      n_eff = LEAVES_MAX;
    end else begin
      n_eff = leaves_r;
    end
  end

  assign in_pos    = in_tdata[9:0];
  assign in_val    = in_tdata[73:10];
  assign in_lo     = in_tdata[84:74];
  assign in_hi     = in_tdata[95:85];
  assign lo_c      = (in_lo > n_eff) ? n_eff : in_lo;
  assign hi_c      = (in_hi > n_eff) ? n_eff : in_hi;
  assign leaf_addr = addr_t'({1'b0, in_pos} + n_eff);
  assign parent    = {1'b0, node_r[ADDR_W-1:1]};
  assign up_max    = smax(cur_r, mem_rdata);
  assign hi_dec    = hi_r - PTR_W'(1);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_nxt       = res_r;
    rd_pend_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_cnt_r;
    mem_wdata     = MOST_NEG;
    mem_raddr     = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == KIND_UPDATE) begin
            // drop updates beyond the leaves in use
            if ({1'b0, in_pos} < n_eff) begin
              mem_we    = 1'b1;
              mem_waddr = leaf_addr;
              mem_wdata = in_val;
              mem_raddr = leaf_addr ^ ADDR_W'(1);
              node_nxt  = leaf_addr;
              cur_nxt   = in_val;
              if (leaf_addr != ROOT_NODE) begin
                state_nxt = ST_UPDATE;
              end
            end
          end else begin
            lo_nxt    = PTR_W'(lo_c) + PTR_W'(n_eff);
            hi_nxt    = PTR_W'(hi_c) + PTR_W'(n_eff);
            res_nxt   = MOST_NEG;
            state_nxt = ST_QUERY;
          end
        end
      end

      ST_UPDATE: begin
        // sibling arrives now: write parent, fetch the parent's sibling
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_max;
        mem_raddr = parent ^ ADDR_W'(1);
        node_nxt  = parent;
        cur_nxt   = up_max;
        if (parent == ROOT_NODE) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_QUERY: begin
        if (rd_pend_r) begin
          res_nxt = smax(res_r, mem_rdata);
        end
        if (lo_r >= hi_r) begin
          // hold until the last node is folded in and the output is free
          if (!rd_pend_r && (!out_valid_r || out_tready)) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = res_r;
            state_nxt     = ST_IDLE;
          end
        end else if (lo_r[0]) begin
          mem_raddr   = lo_r[ADDR_W-1:0];
          rd_pend_nxt = 1'b1;
          lo_nxt      = lo_r + PTR_W'(1);
        end else if (hi_r[0]) begin
          mem_raddr   = hi_dec[ADDR_W-1:0];
          rd_pend_nxt = 1'b1;
          hi_nxt      = hi_dec;
        end else begin
          lo_nxt = lo_r >> 1;
          hi_nxt = hi_r >> 1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      leaves_r    <= LEAVES_MAX;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        leaves_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    cur_r      <= cur_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
